### sv/rotary_position_embedding_defines.svh
// Assertion macros for the rotary position embedding block.
`ifndef ROTARY_POSITION_EMBEDDING_DEFINES_SVH
`define ROTARY_POSITION_EMBEDDING_DEFINES_SVH

// check a property on every clock edge outside reset
`define RPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define RPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rope_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the rotary embedding block.
`default_nettype none

package rope_pkg;

  localparam int HALF_DIM_DEF     = 64;
  localparam int MAX_POS_DEF      = 65536;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam int DIM_W     = 6;
  localparam int POS_W     = 16;
  localparam int FREQ_W    = 32;
  localparam int DATA_W    = 32;
  localparam int MAXPOS_W  = 17;
  localparam int HDIM_W    = 7;
  localparam int ANG_W     = 32;
  localparam int GAIN_W    = 48;
  localparam int ACC_W     = 50;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  localparam logic [MAXPOS_W-1:0] MAXPOS_RST = 17'd65536;
  localparam logic [HDIM_W-1:0]   HDIM_RST   = 7'd64;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_ROTATE = 1'b1;

  localparam logic REG_MAX_POSITIONS    = 1'b0;
  localparam logic REG_ACTIVE_HALF_DIMS = 1'b1;

  typedef struct packed {
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] y;
    logic [ANG_W-1:0] z;
    logic             err;
    logic             last;
  } rope_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } rope_qstat_t;

  function automatic logic [ANG_W-1:0] atan_turn(input int unsigned i);
    logic [ANG_W-1:0] a;
    unique case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### sv/rope_if.sv
// Valid/ready channel interfaces for the rotate/load items and the rotated results.
`default_nettype none

interface rope_in_if import rope_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [DIM_W-1:0]         dim_index;
  logic [FREQ_W-1:0]        freq_value;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] x_first;
  logic signed [DATA_W-1:0] x_second;
  logic                     last_in_vector;

  modport source (output valid, action, dim_index, freq_value, position, x_first, x_second,
                  last_in_vector, input ready);
  modport sink (input valid, action, dim_index, freq_value, position, x_first, x_second,
                last_in_vector, output ready);
endinterface

interface rope_out_if import rope_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] y_first;
  logic signed [DATA_W-1:0] y_second;
  logic                     range_error;
  logic                     last_out;

  modport source (output valid, y_first, y_second, range_error, last_out, input ready);
  modport sink (input valid, y_first, y_second, range_error, last_out, output ready);
endinterface

`default_nettype wire

### sv/rope_front.sv
// Front end: accepts items, writes the frequency table, checks range, forms angle and gained pair.
`default_nettype none

module rope_front import rope_pkg::*; #(
  parameter int HALF_DIM = HALF_DIM_DEF,
  parameter int MAX_POS  = MAX_POS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  rope_in_if.sink                  in_if,
  input  wire logic [MAXPOS_W-1:0] max_positions,
  input  wire logic [HDIM_W-1:0]   active_half_dims,
  input  wire logic                q_full,
  output logic                     push,
  output rope_item_t               push_item
);

  localparam int AW = (HALF_DIM > 1) ? $clog2(HALF_DIM) : 1;

  logic [FREQ_W-1:0] freq_mem [HALF_DIM];
  logic [FREQ_W-1:0] rd_data_r;

  logic              en_f;
  logic              accept;
  logic [7:0]        dim_ext;
  logic [AW-1:0]     idx;
  logic              in_tab;
  logic              err_in;

  logic              f1_valid_r;
  logic [POS_W-1:0]  f1_pos_r;
  logic [DATA_W-1:0] f1_x1_r;
  logic [DATA_W-1:0] f1_x2_r;
  logic              f1_err_r;
  logic              f1_last_r;

  logic              f2_valid_r;
  logic [ANG_W-1:0]  f2_angle_r;
  logic [GAIN_W-1:0] f2_xg_r;
  logic [GAIN_W-1:0] f2_yg_r;
  logic              f2_err_r;
  logic              f2_last_r;

  logic [47:0]       prod_ang;
  logic signed [64:0] prod_x;
  logic signed [64:0] prod_y;

  logic [ANG_W-1:0]  ang_sum;
  logic [1:0]        quad;
  logic [ACC_W-1:0]  xe;
  logic [ACC_W-1:0]  ye;

  assign en_f        = !f2_valid_r || !q_full;
  assign in_if.ready = en_f;
  assign accept      = in_if.valid && en_f;
  assign dim_ext     = {2'b00, in_if.dim_index};
  assign idx         = dim_ext[AW-1:0];
  assign in_tab      = 32'(in_if.dim_index) < HALF_DIM;
  assign err_in      = ({1'b0, in_if.position} >= max_positions) ||
                       (32'(in_if.position) >= MAX_POS) ||
                       ({1'b0, in_if.dim_index} >= active_half_dims) || !in_tab;

  always_ff @(posedge clk) begin
    if (accept && (in_if.action == ACT_LOAD) && in_tab) begin
      freq_mem[idx] <= in_if.freq_value;
    end
    if (accept) begin
      rd_data_r <= freq_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (en_f) begin
      f1_valid_r <= accept && (in_if.action == ACT_ROTATE);
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_pos_r  <= in_if.position;
      f1_x1_r   <= in_if.x_first;
      f1_x2_r   <= in_if.x_second;
      f1_err_r  <= err_in;
      f1_last_r <= in_if.last_in_vector;
    end
  end

  assign prod_ang = f1_pos_r * rd_data_r;
  assign prod_x   = $signed(f1_x1_r) * $signed({1'b0, GAIN_Q32});
  assign prod_y   = $signed(f1_x2_r) * $signed({1'b0, GAIN_Q32});

  always_ff @(posedge clk) begin
    if (en_f) begin
      f2_angle_r <= prod_ang[ANG_W-1:0];
      f2_xg_r    <= prod_x[63:16];
      f2_yg_r    <= prod_y[63:16];
      f2_err_r   <= f1_err_r;
      f2_last_r  <= f1_last_r;
    end
  end

  assign ang_sum = f2_angle_r + 32'h2000_0000;
  assign quad    = ang_sum[31:30];
  assign xe      = {{(ACC_W-GAIN_W){f2_xg_r[GAIN_W-1]}}, f2_xg_r};
  assign ye      = {{(ACC_W-GAIN_W){f2_yg_r[GAIN_W-1]}}, f2_yg_r};

  always_comb begin
    push_item.z    = f2_angle_r - {quad, 30'b0};
    push_item.err  = f2_err_r;
    push_item.last = f2_last_r;
    unique case (quad)
      2'd0: begin
        push_item.x = xe;
        push_item.y = ye;
      end
      2'd1: begin
        push_item.x = -ye;
        push_item.y = xe;
      end
      2'd2: begin
        push_item.x = -xe;
        push_item.y = -ye;
      end
      2'd3: begin
        push_item.x = ye;
        push_item.y = -xe;
      end
    endcase
  end

  assign push = f2_valid_r && !q_full;

endmodule

`default_nettype wire

### sv/rope_queue.sv
// Short queue between the front end and the CORDIC pipeline.
`default_nettype none

module rope_queue import rope_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire rope_item_t  push_item,
  input  wire logic        pop,
  output rope_item_t       head,
  output rope_qstat_t      stat
);

  rope_item_t        entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  assign head       = entries_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = count_r == QCNT_W'(QUEUE_DEPTH);
  assign stat.empty = count_r == '0;

endmodule

`default_nettype wire

### sv/rope_back.sv
// Back end: pipelined CORDIC rotation, rounding, saturation and the output register.
`default_nettype none

module rope_back import rope_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rope_item_t head,
  input  wire logic       q_empty,
  output logic            pop,
  rope_out_if.source      out_if
);

  localparam logic [ACC_W:0] RND_HALF = {{(ACC_W-15){1'b0}}, 1'b1, 15'b0};

  rope_item_t          st_r   [CORDIC_STEPS+1];
  rope_item_t          st_nxt [1:CORDIC_STEPS];
  logic [CORDIC_STEPS:0] st_valid_r;

  logic              en_b;
  logic              out_valid_r;
  logic [DATA_W-1:0] y_first_r;
  logic [DATA_W-1:0] y_second_r;
  logic              err_r;
  logic              last_r;

  function automatic logic [DATA_W-1:0] to_q16(input logic [ACC_W-1:0] v);
    logic signed [ACC_W:0]    s;
    logic signed [ACC_W-16:0] r;
    s = $signed({v[ACC_W-1], v}) + $signed(RND_HALF);
    r = s[ACC_W:16];
    if ((&r[ACC_W-16:DATA_W-1]) || !(|r[ACC_W-16:DATA_W-1])) begin
      return r[DATA_W-1:0];
    end else if (r[ACC_W-16]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  assign en_b = !out_valid_r || out_if.ready;
  assign pop  = !q_empty && en_b;

  for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_step
    localparam logic [ANG_W-1:0] ATAN_K = atan_turn(k - 1);
    logic signed [ACC_W-1:0] dx;
    logic signed [ACC_W-1:0] dy;
    always_comb begin
      dx        = $signed(st_r[k-1].y) >>> (k - 1);
      dy        = $signed(st_r[k-1].x) >>> (k - 1);
      st_nxt[k] = st_r[k-1];
      if (!st_r[k-1].z[ANG_W-1]) begin
        st_nxt[k].x = st_r[k-1].x - dx;
        st_nxt[k].y = st_r[k-1].y + dy;
        st_nxt[k].z = st_r[k-1].z - ATAN_K;
      end else begin
        st_nxt[k].x = st_r[k-1].x + dx;
        st_nxt[k].y = st_r[k-1].y - dy;
        st_nxt[k].z = st_r[k-1].z + ATAN_K;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (en_b) begin
      st_valid_r  <= {st_valid_r[CORDIC_STEPS-1:0], !q_empty};
      out_valid_r <= st_valid_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      st_r[0] <= head;
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        st_r[k] <= st_nxt[k];
      end
      y_first_r  <= st_r[CORDIC_STEPS].err ? '0 : to_q16(st_r[CORDIC_STEPS].x);
      y_second_r <= st_r[CORDIC_STEPS].err ? '0 : to_q16(st_r[CORDIC_STEPS].y);
      err_r      <= st_r[CORDIC_STEPS].err;
      last_r     <= st_r[CORDIC_STEPS].last;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.y_first     = y_first_r;
  assign out_if.y_second    = y_second_r;
  assign out_if.range_error = err_r;
  assign out_if.last_out    = last_r;

endmodule

`default_nettype wire

### sv/rotary_position_embedding.sv
// Top level of the rotary position embedding pair rotator with its APB register file.
// A rotate item passes registers f1 and f2, the queue, the CORDIC stages and the output.
// Throughput: one item per cycle when not stalled; one CORDIC stage per micro-rotation.
// A load item writes the frequency table and yields no result.
// Synchronous active-low reset clears all valid flags, sets max_positions to 65536 and
// active_half_dims to 64; frequency table contents are undefined until loaded.
`default_nettype none

`include "rotary_position_embedding_defines.svh"

module rotary_position_embedding import rope_pkg::*; #(
  parameter int HALF_DIM     = HALF_DIM_DEF,
  parameter int MAX_POS      = MAX_POS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  rope_in_if.sink                 in_if,
  rope_out_if.source              out_if,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [MAXPOS_W-1:0] max_positions_r;
  logic [HDIM_W-1:0]   active_half_dims_r;
  logic                cfg_wr;

  logic        q_push;
  logic        q_pop;
  rope_item_t  q_push_item;
  rope_item_t  q_head;
  rope_qstat_t q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_positions_r    <= MAXPOS_RST;
      active_half_dims_r <= HDIM_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX_POSITIONS:    max_positions_r    <= pwdata[MAXPOS_W-1:0];
        REG_ACTIVE_HALF_DIMS: active_half_dims_r <= pwdata[HDIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_POSITIONS:    prdata = PDATA_W'(max_positions_r);
      REG_ACTIVE_HALF_DIMS: prdata = PDATA_W'(active_half_dims_r);
    endcase
  end

  rope_front #(
    .HALF_DIM (HALF_DIM),
    .MAX_POS  (MAX_POS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_if            (in_if),
    .max_positions    (max_positions_r),
    .active_half_dims (active_half_dims_r),
    .q_full           (q_stat.full),
    .push             (q_push),
    .push_item        (q_push_item)
  );

  rope_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  rope_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_stat.empty),
    .pop     (q_pop),
    .out_if  (out_if)
  );

  `RPE_ASSERT(a_err_zero, out_if.valid && out_if.range_error |-> out_if.y_first == '0 && out_if.y_second == '0, "range error result carries nonzero data")
  `RPE_ASSERT(a_q_bound, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `RPE_ASSERT(a_q_track, q_push && !q_pop |=> q_stat.count == QCNT_W'($past(q_stat.count) + 1'b1), "queue count lost a push")
  `RPE_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_if.valid && q_stat.empty, "block not idle after reset")

endmodule

`default_nettype wire
